// ===== rtl/rgbnv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbnv_pkg
// Shared types, constants and arithmetic helpers of the RGB to NV12 converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbnv_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int WIDTH_W       = 12;
  localparam int HEIGHT_W      = 13;
  localparam int ROW_W         = 12;
  localparam int ROW_LIMIT     = 4096;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int SUM_W         = 9;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd1280;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd640;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb_value;
    logic [7:0] cr_value;
    logic       end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } pair_sum_t;

  typedef struct packed {
    logic line_wr;
    logic line_rd;
    logic eof;
  } raster_ctl_t;

  function automatic logic [7:0] luma_of(input in_item_t p);
    logic [15:0] acc;
    acc = 16'(16'd77 * 16'(p.red)) + 16'(16'd150 * 16'(p.green))
        + 16'(16'd29 * 16'(p.blue));
    return acc[15:8];
  endfunction

  function automatic logic [7:0] avg4(input logic [SUM_W-1:0] a,
                                      input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W:2];
  endfunction

  function automatic logic signed [16:0] cb_sum(input logic [7:0] ar,
                                                input logic [7:0] ag,
                                                input logic [7:0] ab);
    logic signed [17:0] t;
    t = -(18'sd43 * $signed({10'b0, ar})) - (18'sd85 * $signed({10'b0, ag}))
        + (18'sd128 * $signed({10'b0, ab}));
    return 17'(t);
  endfunction

  function automatic logic signed [16:0] cr_sum(input logic [7:0] ar,
                                                input logic [7:0] ag,
                                                input logic [7:0] ab);
    logic signed [17:0] t;
    t = (18'sd128 * $signed({10'b0, ar})) - (18'sd107 * $signed({10'b0, ag}))
        - (18'sd21 * $signed({10'b0, ab}));
    return 17'(t);
  endfunction

  // floor(t / 256) + 128, clamped to a byte
  function automatic logic [7:0] to_byte(input logic signed [16:0] t);
    logic signed [16:0] sh;
    logic signed [9:0]  v;
    sh = t >>> 8;
    v  = 10'(sh) + 10'sd128;
    if (v < 10'sd0) begin
      return 8'd0;
    end else if (v > 10'sd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbnv_lbuf.sv =====
// ----------------------------------------------------------------------------
// rgbnv_lbuf
// Line buffer of horizontal pair sums: one write port, one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbnv_lbuf #(
  parameter int AW = 10
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire rgbnv_pkg::pair_sum_t wr_data,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  output rgbnv_pkg::pair_sum_t     rd_data
);
  import rgbnv_pkg::*;

  localparam int DEPTH = 1 << AW;

  pair_sum_t mem [0:DEPTH-1];
  pair_sum_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/rgbnv_raster.sv =====
// ----------------------------------------------------------------------------
// rgbnv_raster
// Column/row tracking, left pixel hold, pair sums, luma and line buffer control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbnv_raster #(
  parameter int MAX_WIDTH = rgbnv_pkg::DEF_MAX_WIDTH,
  parameter int AW        = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            accept,
  input  wire rgbnv_pkg::in_item_t             pix,
  input  wire logic [rgbnv_pkg::WIDTH_W-1:0]   row_pixels,
  input  wire logic [rgbnv_pkg::HEIGHT_W-1:0]  frame_rows,
  output logic [7:0]                           luma,
  output rgbnv_pkg::pair_sum_t                 pair_sum,
  output logic [AW-1:0]                        line_addr,
  output rgbnv_pkg::raster_ctl_t               ctl
);
  import rgbnv_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  in_item_t         left_r, left_nxt;

  logic [WW-1:0]       w_ext, w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic                row_end, frame_end, odd_col, odd_row;

  always_comb begin
    w_ext = WW'(row_pixels);
    if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else if (w_ext == '0) begin
      w_eff = WW'(1);
    end else begin
      w_eff = w_ext;
    end
    if (frame_rows > HEIGHT_W'(ROW_LIMIT)) begin
      h_eff = HEIGHT_W'(ROW_LIMIT);
    end else if (frame_rows == '0) begin
      h_eff = HEIGHT_W'(1);
    end else begin
      h_eff = frame_rows;
    end
  end

  assign odd_col   = col_r[0];
  assign odd_row   = row_r[0];
  assign row_end   = (WW'(col_r) + WW'(1)) >= w_eff;
  assign frame_end = row_end && ((HEIGHT_W'(row_r) + HEIGHT_W'(1)) >= h_eff);

  assign luma       = luma_of(pix);
  assign pair_sum.r = SUM_W'(left_r.red)   + SUM_W'(pix.red);
  assign pair_sum.g = SUM_W'(left_r.green) + SUM_W'(pix.green);
  assign pair_sum.b = SUM_W'(left_r.blue)  + SUM_W'(pix.blue);
  assign line_addr  = AW'(col_r >> 1);

  assign ctl.line_wr = odd_col && !odd_row;
  assign ctl.line_rd = odd_col && odd_row;
  assign ctl.eof     = frame_end;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    if (accept) begin
      if (!odd_col) begin
        left_nxt = pix;
      end
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgb_to_nv12_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_nv12_converter
// RGB pixels in raster order to luma per pixel and 4:2:0 BT.601 chroma.
// ----------------------------------------------------------------------------
//   channel  dir  handshake        payload
//   in_      in   valid / stall    in_item  (red, green, blue)
//   out_     out  valid / stall    out_item (luma, chroma, end_of_frame)
//   cfg_     in   valid / ready    cfg_index, cfg_data
//
// One pixel per cycle while in_stall is low; three register stages (line buffer
// read, chroma weighting, output register) lie between accept and out_valid.
// Each stage loads when it is empty or the next stage moves, so bubbles fill
// while out_stall is high. cfg_ready is always high.
// Reset (rst_n low, synchronous) clears counters and valids; the line buffer
// needs no clearing: each entry is written on an even row before its odd-row read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_nv12_converter #(
  parameter int MAX_WIDTH = rgbnv_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire rgbnv_pkg::in_item_t               in_item,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output rgbnv_pkg::out_item_t                   out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rgbnv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rgbnv_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rgbnv_pkg::*;

  localparam int AW = (MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;

  logic        accept, en1, en2, en3;
  logic [7:0]  luma0;
  pair_sum_t   ps0, rd_data;
  logic [AW-1:0] line_addr;
  raster_ctl_t ctl0;

  logic        v1_r, blk1_r, eof1_r;
  logic [7:0]  luma1_r;
  pair_sum_t   ps1_r;

  logic              v2_r, blk2_r, eof2_r;
  logic [7:0]        luma2_r;
  logic signed [16:0] cbt2_r, crt2_r;
  logic [7:0]        ar, ag, ab;

  logic      out_valid_r;
  out_item_t out_item_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FRAME_WIDTH) begin
        width_r <= cfg_data[WIDTH_W-1:0];
      end else if (cfg_index == CFG_FRAME_HEIGHT) begin
        height_r <= cfg_data[HEIGHT_W-1:0];
      end
    end
  end

  // stage enables
  assign en3      = !out_valid_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  rgbnv_raster #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_raster (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .pix        (in_item),
    .row_pixels (width_r),
    .frame_rows (height_r),
    .luma       (luma0),
    .pair_sum   (ps0),
    .line_addr  (line_addr),
    .ctl        (ctl0)
  );

  rgbnv_lbuf #(
    .AW (AW)
  ) u_lbuf (
    .clk     (clk),
    .wr_en   (accept && ctl0.line_wr),
    .wr_addr (line_addr),
    .wr_data (ps0),
    .rd_en   (accept && ctl0.line_rd),
    .rd_addr (line_addr),
    .rd_data (rd_data)
  );

  // stage 1: line read returns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      luma1_r <= luma0;
      blk1_r  <= ctl0.line_rd;
      eof1_r  <= ctl0.eof;
      ps1_r   <= ps0;
    end
  end

  // stage 2: 2x2 average and chroma weighting
  assign ar = avg4(ps1_r.r, rd_data.r);
  assign ag = avg4(ps1_r.g, rd_data.g);
  assign ab = avg4(ps1_r.b, rd_data.b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      luma2_r <= luma1_r;
      blk2_r  <= blk1_r;
      eof2_r  <= eof1_r;
      cbt2_r  <= cb_sum(ar, ag, ab);
      crt2_r  <= cr_sum(ar, ag, ab);
    end
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      out_item_r.luma         <= luma2_r;
      out_item_r.chroma_valid <= blk2_r;
      out_item_r.cb_value     <= blk2_r ? to_byte(cbt2_r) : 8'd0;
      out_item_r.cr_value     <= blk2_r ? to_byte(crt2_r) : 8'd0;
      out_item_r.end_of_frame <= eof2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
